// File: hdl/sidac_pkg.sv
package sidac_pkg;

  localparam int Digits       = 10;
  localparam int BcdWidth     = 4 * Digits;
  localparam int ValueWidth   = 32;
  localparam int BitsPerStage = 8;
  localparam int ConvStages   = ValueWidth / BitsPerStage;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // One item in flight: sign, BCD built so far, binary bits not yet shifted in.
  typedef struct packed {
    logic                  neg;
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
  } conv_t;

  // Eight double-dabble steps: correct each digit, then shift one binary bit in.
  function automatic logic [BcdWidth-1:0] dabble_step8(
    input logic [BcdWidth-1:0]     bcd_in,
    input logic [BitsPerStage-1:0] bits
  );
    logic [BcdWidth-1:0] acc;
    acc = bcd_in;
    for (int s = BitsPerStage - 1; s >= 0; s--) begin
      for (int d = 0; d < Digits; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BcdWidth-2:0], bits[s]};
    end
    return acc;
  endfunction

endpackage

// File: hdl/sidac_serializer.sv
module sidac_serializer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  sidac_pkg::conv_t       item,
  output logic                   ready,
  output logic                   strobe,
  output logic [7:0]             character,
  output logic                   last_char
);
  import sidac_pkg::*;

  logic                active;
  logic                minus_pend;
  logic [3:0]          pos;
  logic [BcdWidth-1:0] digits;
  logic [3:0]          first_idx;
  logic [3:0]          cur_digit;
  logic                at_last;

  // Highest nonzero digit; zero gives index 0 so a lone '0' comes out.
  always_comb begin
    first_idx = 4'd0;
    for (int i = 0; i < Digits; i++) begin
      if (item.bcd[4*i +: 4] != 4'd0) begin
        first_idx = 4'(i);
      end
    end
  end

  assign cur_digit = digits[{pos, 2'b00} +: 4];
  assign at_last   = !minus_pend && (pos == 4'd0);
  assign ready     = !active || at_last;
  assign strobe    = active;
  assign character = minus_pend ? ASCII_MINUS : (ASCII_ZERO + {4'd0, cur_digit});
  assign last_char = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      minus_pend <= 1'b0;
    end else if (load) begin
      active     <= 1'b1;
      minus_pend <= item.neg;
      pos        <= first_idx;
      digits     <= item.bcd;
    end else if (active) begin
      if (minus_pend) begin
        minus_pend <= 1'b0;
      end else if (pos == 4'd0) begin
        active <= 1'b0;
      end else begin
        pos <= pos - 4'd1;
      end
    end
  end

endmodule

// File: hdl/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII text. An item is taken when start is
// high and busy is low. Its characters leave most significant first, one per
// cycle with strobe high, a '-' first for a negative value, and last_char on the
// final digit; the receiver cannot stall, so every strobed character must be
// taken in that cycle. The first character reaches the ports through the input
// register, four double-dabble stages of eight bits each, then the character
// serializer. An item has 1 to 11 characters; up to five further items wait in
// the pipeline, so a new item can be taken before earlier ones have left. busy
// is high while the input stage is full and cannot move on.
module signed_int_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value,
  output logic        busy,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last_char
);
  import sidac_pkg::*;

  // Stage 0 holds the magnitude; stages 1..ConvStages run the conversion.
  conv_t                stage [ConvStages+1];
  logic [ConvStages:0]  valid;
  logic [ConvStages:0]  move;
  logic [ConvStages+1:0] free;
  logic                 ser_ready;
  logic                 take;

  // Backpressure ripples from the serializer toward the input.
  always_comb begin
    free[ConvStages+1] = ser_ready;
    for (int i = ConvStages; i >= 0; i--) begin
      move[i] = valid[i] && free[i+1];
      free[i] = !valid[i] || move[i];
    end
  end

  assign busy = !free[0];
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (take) begin
        valid[0] <= 1'b1;
      end else if (move[0]) begin
        valid[0] <= 1'b0;
      end
      for (int i = 1; i <= ConvStages; i++) begin
        if (move[i-1]) begin
          valid[i] <= 1'b1;
        end else if (move[i]) begin
          valid[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage[0].neg <= value[31];
      stage[0].bcd <= '0;
      stage[0].bin <= value[31] ? (32'd0 - value) : value;
    end
  end

  for (genvar g = 1; g <= ConvStages; g++) begin : g_conv
    always_ff @(posedge clk) begin
      if (move[g-1]) begin
        stage[g].neg <= stage[g-1].neg;
        stage[g].bcd <= dabble_step8(stage[g-1].bcd,
                                     stage[g-1].bin[ValueWidth-1 -: BitsPerStage]);
        stage[g].bin <= {stage[g-1].bin[ValueWidth-BitsPerStage-1:0],
                         {BitsPerStage{1'b0}}};
      end
    end
  end

  sidac_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (move[ConvStages]),
    .item      (stage[ConvStages]),
    .ready     (ser_ready),
    .strobe    (strobe),
    .character (character),
    .last_char (last_char)
  );

endmodule

// File: tb/signed_int_to_decimal_ascii_top_test.sv
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_top_test;
  import sidac_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  typedef struct {
    logic [31:0] value;
    string       text;   // empty: expected text comes from the predictor
  } text_case_t;

  localparam int NumCases    = 22;
  localparam int NumRandom   = 440;
  localparam int DrainCycles = 16;
  localparam int Radix       = 10;
  localparam int GapPercent  = 31;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] value = '0;
  logic        busy;
  logic        strobe;
  logic [7:0]  character;
  logic        last_char;

  text_char_t expected_chars[$];
  int         fail_count = 0;
  int         item_count = 0;

  text_case_t text_cases[NumCases] = '{
    '{32'd0,          "0"},
    '{32'h8000_0000,  "-2147483648"},
    '{32'h7FFF_FFFF,  "2147483647"},
    '{-32'sd1,        "-1"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{-32'sd9,        "-9"},
    '{32'd10,         "10"},
    '{-32'sd10,       "-10"},
    '{32'd99,         "99"},
    '{32'd100,        "100"},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{-32'sd1000000000, "-1000000000"},
    '{32'h8000_0001,  "-2147483647"},
    '{32'd12345,      ""},
    '{-32'sd987654321, ""},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'h0000_FFFF,  ""},
    '{32'hFFFF_0000,  ""},
    '{32'd42,         ""}
  };

  signed_int_to_decimal_ascii_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .value    (value),
    .busy     (busy),
    .strobe   (strobe),
    .character(character),
    .last_char(last_char)
  );

  always #4 clk = ~clk;

  // Digits come from the unsigned magnitude, so the most negative value works.
  function automatic void push_decimal(logic [31:0] v);
    logic [31:0] mag;
    logic [7:0]  digit_codes[10];
    int          nd;
    mag = v[31] ? -v : v;
    nd  = 0;
    do begin
      digit_codes[nd] = ASCII_ZERO + 8'(mag % Radix);
      nd++;
      mag = mag / Radix;
    end while (mag != 0);
    if (v[31]) begin
      expected_chars.push_back('{ASCII_MINUS, 1'b0});
    end
    for (int k = nd - 1; k >= 0; k--) begin
      expected_chars.push_back('{digit_codes[k], k == 0});
    end
  endfunction

  function automatic logic [31:0] random_value();
    longint unsigned scale;
    logic [31:0]     v;
    int              sel;
    scale = 1;
    sel   = $urandom_range(4);
    for (int k = $urandom_range(9); k > 0; k--) begin
      scale *= Radix;
    end
    case (sel)
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: v = 32'(scale) - 32'($urandom_range(1));   // power of ten or just below
      3: v = 32'(longint'($urandom) % scale);      // random digit count
      default: begin
        if ($urandom_range(1)) begin
          v = 32'h7FFF_FFFF - 32'($urandom_range(3));
        end else begin
          v = 32'h8000_0000 + 32'($urandom_range(3));
        end
      end
    endcase
    if (sel != 0 && sel < 4 && $urandom_range(1)) begin
      v = -v;
    end
    return v;
  endfunction

  // No gaps in a stretch of the random part.
  function automatic bit take_gap();
    return (item_count < 150 || item_count >= 250) && $urandom_range(99) < GapPercent;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(logic [31:0] v, string text);
    while (take_gap()) begin
      start = 1'b0;
      value = $urandom;
      @(negedge clk);
    end
    start = 1'b1;
    value = v;
    do @(posedge clk); while (busy);
    if (text.len() == 0) begin
      push_decimal(v);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        expected_chars.push_back('{text[i], i == text.len() - 1});
      end
    end
    item_count++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        $error("character %h with no item pending", character);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (character !== want.code) begin
          $error("character: expected %h, got %h", want.code, character);
          fail_count++;
        end
        if (last_char !== want.last) begin
          $error("last_char: expected %b, got %b", want.last, last_char);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    foreach (text_cases[i]) begin
      send_item(text_cases[i].value, text_cases[i].text);
    end
    repeat (NumRandom) begin
      send_item(random_value(), "");
    end
    start = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("** signed_int_to_decimal_ascii_top: PASSED **");
    end else begin
      $display("** signed_int_to_decimal_ascii_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** signed_int_to_decimal_ascii_top: FAILED **");
    $finish;
  end

endmodule
